FILE: rtl/core/bb3_pkg.sv
// shared types and constants for the 3x3 box blur core
`default_nettype none
package bb3_pkg;

  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 4096;

  localparam int CH_W   = 8;
  localparam int PIX_W  = 3 * CH_W;
  localparam int COL_W  = $clog2(MAX_WIDTH);
  localparam int ROW_W  = $clog2(MAX_HEIGHT);
  localparam int WID_W  = 11;
  localparam int HGT_W  = 13;
  localparam int SUM_W  = 12;
  localparam int LINE_W = 2 * PIX_W;

  // register indexes of the configuration port
  localparam logic CFG_WIDTH  = 1'b0;
  localparam logic CFG_HEIGHT = 1'b1;

  localparam logic [WID_W-1:0] WIDTH_RESET  = 11'd1024;
  localparam logic [HGT_W-1:0] HEIGHT_RESET = 13'd768;
  localparam logic [WID_W-1:0] WIDTH_MIN    = 11'd3;
  localparam logic [WID_W-1:0] WIDTH_MAX    = 11'd1024;
  localparam logic [HGT_W-1:0] HEIGHT_MIN   = 13'd3;
  localparam logic [HGT_W-1:0] HEIGHT_MAX   = 13'd4096;

  // floor(x / 9) for x <= 2295 as (x * 3641) >> 15
  localparam logic [11:0] DIV9_MUL   = 12'd3641;
  localparam int          DIV9_SHIFT = 15;

  typedef logic [PIX_W-1:0] pix_t;
  typedef logic [SUM_W-1:0] sum_t;

  typedef struct packed {
    sum_t             sum_a;
    sum_t             sum_b;
    sum_t             sum_c;
    logic [ROW_W-1:0] blur_row;
    logic [COL_W-1:0] blur_col;
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
    pix_t             pix;
    logic             blur;
    logic             border;
  } s2_item_t;

endpackage
`default_nettype wire

FILE: rtl/core/bb3_line_store.sv
// two line stores packed in one memory, registered read with write forwarding
`default_nettype none
module bb3_line_store
  import bb3_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              rd_en,
  input  wire logic [COL_W-1:0]  rd_addr,
  input  wire logic              wr_en,
  input  wire logic [COL_W-1:0]  wr_addr,
  input  wire logic [LINE_W-1:0] wr_data,
  output logic      [LINE_W-1:0] rd_data
);

  logic [LINE_W-1:0] mem [MAX_WIDTH];
  logic [LINE_W-1:0] q_r;
  logic [LINE_W-1:0] fwd_data_r;
  logic              fwd_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      q_r        <= mem[rd_addr];
      fwd_data_r <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fwd_r <= 1'b0;
    end else if (rd_en) begin
      fwd_r <= wr_en && (wr_addr == rd_addr);
    end
  end

  assign rd_data = fwd_r ? fwd_data_r : q_r;

endmodule
`default_nettype wire

FILE: rtl/core/bb3_window.sv
// 3x3 pixel window with per-channel sums of the shifted window
`default_nettype none
module bb3_window
  import bb3_pkg::*;
(
  input  wire logic clk,
  input  wire logic shift_en,
  input  wire pix_t top_pix,
  input  wire pix_t mid_pix,
  input  wire pix_t bot_pix,
  output sum_t      sum_a,
  output sum_t      sum_b,
  output sum_t      sum_c
);

  pix_t win_r [9];
  pix_t win_nxt [9];
  sum_t sums [3];

  always_comb begin
    win_nxt[0] = win_r[1];
    win_nxt[1] = win_r[2];
    win_nxt[2] = top_pix;
    win_nxt[3] = win_r[4];
    win_nxt[4] = win_r[5];
    win_nxt[5] = mid_pix;
    win_nxt[6] = win_r[7];
    win_nxt[7] = win_r[8];
    win_nxt[8] = bot_pix;
  end

  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      sums[ch] = '0;
      for (int k = 0; k < 9; k++) begin
        sums[ch] = sums[ch] + sum_t'(win_nxt[k][ch*CH_W +: CH_W]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (shift_en) begin
      for (int k = 0; k < 9; k++) begin
        win_r[k] <= win_nxt[k];
      end
    end
  end

  assign sum_a = sums[0];
  assign sum_b = sums[1];
  assign sum_c = sums[2];

endmodule
`default_nettype wire

FILE: rtl/core/bb3_out_stage.sv
// divide-by-nine stage and result sequencer, up to two results per pixel
`default_nettype none
module bb3_out_stage
  import bb3_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             s2_load,
  input  wire s2_item_t         s2_in,
  output logic                  s2_free,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output logic      [ROW_W-1:0] out_row,
  output logic      [COL_W-1:0] out_col,
  output pix_t                  out_pix,
  output logic                  out_last
);

  function automatic logic [CH_W-1:0] div9(input sum_t x);
    logic [2*SUM_W-1:0] p;
    begin
      p    = (2*SUM_W)'(x) * (2*SUM_W)'(DIV9_MUL);
      div9 = p[DIV9_SHIFT +: CH_W];
    end
  endfunction

  s2_item_t         s2_r;
  logic             s2_valid_r;
  logic             pend_blur_r;
  logic             pend_bord_r;
  logic             out_valid_r;
  logic [ROW_W-1:0] out_row_r;
  logic [COL_W-1:0] out_col_r;
  pix_t             out_pix_r;
  logic             out_last_r;

  logic out_load;
  logic emit;
  logic s2_done;
  pix_t avg;

  assign out_load = !out_valid_r || out_ready;
  assign emit     = s2_valid_r && out_load && (pend_blur_r || pend_bord_r);
  assign s2_done  = s2_valid_r && ((!pend_blur_r && !pend_bord_r) ||
                                   (out_load && !(pend_blur_r && pend_bord_r)));
  assign s2_free  = !s2_valid_r || s2_done;
  assign avg      = {div9(s2_r.sum_c), div9(s2_r.sum_b), div9(s2_r.sum_a)};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r  <= 1'b0;
      pend_blur_r <= 1'b0;
      pend_bord_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (s2_load) begin
        s2_valid_r  <= 1'b1;
        pend_blur_r <= s2_in.blur;
        pend_bord_r <= s2_in.border;
      end else if (s2_done) begin
        s2_valid_r  <= 1'b0;
      end else if (emit && pend_blur_r && pend_bord_r) begin
        pend_blur_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s2_load) begin
      s2_r <= s2_in;
    end
    if (emit) begin
      if (pend_blur_r) begin
        out_row_r  <= s2_r.blur_row;
        out_col_r  <= s2_r.blur_col;
        out_pix_r  <= avg;
        out_last_r <= !pend_bord_r;
      end else begin
        out_row_r  <= s2_r.row;
        out_col_r  <= s2_r.col;
        out_pix_r  <= s2_r.pix;
        out_last_r <= 1'b1;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_row   = out_row_r;
  assign out_col   = out_col_r;
  assign out_pix   = out_pix_r;
  assign out_last  = out_last_r;

endmodule
`default_nettype wire

FILE: rtl/core/box_blur_3x3_rgb_core.sv
// top level of the streaming 3x3 box blur over 24-bit pixels
// path: stage-1 registers, then the stage-2 register, then the output register
// throughput: one pixel per cycle while out_tready is high; a pixel with two results holds the
// input back while the single output register passes its results in turn
// reset: synchronous active-low rst_n clears position counters, valid flags and
// sets width 1024 / height 768; line stores and window are not cleared
`default_nettype none
module box_blur_3x3_rgb_core
  import bb3_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_tvalid,
  output logic                   in_tready,
  input  wire logic [23:0]       in_tdata,   // chan_a, chan_b, chan_c
  input  wire logic              in_tuser,   // frame_start
  output logic                   out_tvalid,
  input  wire logic              out_tready,
  output logic      [47:0]       out_tdata,  // out_row, out_col, out_a, out_b, out_c, zero pad
  output logic                   out_tlast,
  input  wire logic              cfg_valid,
  output logic                   cfg_ready,
  input  wire logic              cfg_index,
  input  wire logic [HGT_W-1:0]  cfg_data
);

  logic [WID_W-1:0] width_r;
  logic [HGT_W-1:0] height_r;
  logic [COL_W-1:0] col_r;
  logic [ROW_W-1:0] row_r;

  logic             s1_valid_r;
  pix_t             s1_pix_r;
  logic [ROW_W-1:0] s1_row_r;
  logic [COL_W-1:0] s1_col_r;
  logic             s1_blur_r;
  logic             s1_border_r;

  logic [WID_W-1:0]  w;
  logic [HGT_W-1:0]  h;
  logic              in_acc;
  logic              s1_adv;
  logic              s2_free;
  logic              restart;
  logic [ROW_W-1:0]  r;
  logic [COL_W-1:0]  c;
  logic [WID_W-1:0]  c_inc;
  logic [HGT_W-1:0]  r_inc;
  logic [LINE_W-1:0] line_rd;
  logic [LINE_W-1:0] line_wr;
  sum_t              sum_a;
  sum_t              sum_b;
  sum_t              sum_c;
  s2_item_t          s2_item;
  logic [ROW_W-1:0]  res_row;
  logic [COL_W-1:0]  res_col;
  pix_t              res_pix;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= WIDTH_RESET;
      height_r <= HEIGHT_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_WIDTH:  width_r  <= cfg_data[WID_W-1:0];
        CFG_HEIGHT: height_r <= cfg_data;
        default:    ;
      endcase
    end
  end

  assign w = (width_r < WIDTH_MIN) ? WIDTH_MIN :
             (width_r > WIDTH_MAX) ? WIDTH_MAX : width_r;
  assign h = (height_r < HEIGHT_MIN) ? HEIGHT_MIN :
             (height_r > HEIGHT_MAX) ? HEIGHT_MAX : height_r;

  assign s1_adv    = s1_valid_r && s2_free;
  assign in_tready = !s1_valid_r || s1_adv;
  assign in_acc    = in_tvalid && in_tready;

  assign restart = in_tuser || ({1'b0, col_r} >= w) || ({1'b0, row_r} >= h);
  assign r       = restart ? '0 : row_r;
  assign c       = restart ? '0 : col_r;
  assign c_inc   = {1'b0, c} + 11'd1;
  assign r_inc   = {1'b0, r} + 13'd1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r      <= '0;
      row_r      <= '0;
      s1_valid_r <= 1'b0;
    end else begin
      if (in_acc) begin
        s1_valid_r <= 1'b1;
        if (c_inc >= w) begin
          col_r <= '0;
          row_r <= (r_inc >= h) ? '0 : r_inc[ROW_W-1:0];
        end else begin
          col_r <= c_inc[COL_W-1:0];
          row_r <= r;
        end
      end else if (s1_adv) begin
        s1_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_pix_r    <= in_tdata;
      s1_row_r    <= r;
      s1_col_r    <= c;
      s1_blur_r   <= (r >= 12'd2) && (c >= 10'd2);
      s1_border_r <= (r == '0) || ({1'b0, r} == h - 13'd1) ||
                     (c == '0) || ({1'b0, c} == w - 11'd1);
    end
  end

  assign line_wr = {line_rd[PIX_W-1:0], s1_pix_r};

  bb3_line_store u_line_store (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (in_acc),
    .rd_addr (c),
    .wr_en   (s1_adv),
    .wr_addr (s1_col_r),
    .wr_data (line_wr),
    .rd_data (line_rd)
  );

  bb3_window u_window (
    .clk      (clk),
    .shift_en (s1_adv),
    .top_pix  (line_rd[LINE_W-1:PIX_W]),
    .mid_pix  (line_rd[PIX_W-1:0]),
    .bot_pix  (s1_pix_r),
    .sum_a    (sum_a),
    .sum_b    (sum_b),
    .sum_c    (sum_c)
  );

  always_comb begin
    s2_item.sum_a    = sum_a;
    s2_item.sum_b    = sum_b;
    s2_item.sum_c    = sum_c;
    s2_item.blur_row = s1_row_r - 12'd1;
    s2_item.blur_col = s1_col_r - 10'd1;
    s2_item.row      = s1_row_r;
    s2_item.col      = s1_col_r;
    s2_item.pix      = s1_pix_r;
    s2_item.blur     = s1_blur_r;
    s2_item.border   = s1_border_r;
  end

  bb3_out_stage u_out_stage (
    .clk       (clk),
    .rst_n     (rst_n),
    .s2_load   (s1_adv),
    .s2_in     (s2_item),
    .s2_free   (s2_free),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_row   (res_row),
    .out_col   (res_col),
    .out_pix   (res_pix),
    .out_last  (out_tlast)
  );

  assign out_tdata = {2'b00, res_pix, res_col, res_row};

endmodule
`default_nettype wire
